[sv/frame_bitmap_allocator_macros.svh]
// Assertion helpers. The clock is clk and the reset is rst_n, active low.
`ifndef FRAME_BITMAP_ALLOCATOR_MACROS_SVH
`define FRAME_BITMAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define FBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FBA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/fba_pkg.sv]
package fba_pkg;

  localparam int FRAME_W = 17;
  localparam int COUNT_W = 18;

  localparam logic [COUNT_W-1:0] TF_RESET = 18'd131072;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_NOOP = 2'd1,
    ST_FULL = 2'd2
  } status_t;

endpackage

[sv/fba_req_if.sv]
interface fba_req_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [fba_pkg::FRAME_W-1:0] page_frame;
  logic                        kernel_mode;
  logic                        want_write;

  modport source (output valid, output func, output page_frame, output kernel_mode,
                  output want_write, input ready);
  modport sink   (input valid, input func, input page_frame, input kernel_mode,
                  input want_write, output ready);
endinterface

[sv/fba_rsp_if.sv]
interface fba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [fba_pkg::FRAME_W-1:0] frame_number;
  logic                        present;
  logic                        writable;
  logic                        user_mode;
  logic [1:0]                  status;
  logic [fba_pkg::COUNT_W-1:0] used_count;

  modport source (output valid, output frame_number, output present, output writable,
                  output user_mode, output status, output used_count, input ready);
  modport sink   (input valid, input frame_number, input present, input writable,
                  input user_mode, input status, input used_count, output ready);
endinterface

[sv/fba_cfg_if.sv]
interface fba_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [fba_pkg::COUNT_W-1:0] frame_limit;

  modport source (output valid, output frame_limit, input ready);
  modport sink   (input valid, input frame_limit, output ready);
endinterface

[sv/frame_bitmap_allocator.sv]
// First-fit page frame allocator over a used map of one bit per frame, kept in a
// single-port-read, single-port-write RAM of MAX_FRAMES/WORD_BITS words. After reset
// the block sweeps all MAX_FRAMES/WORD_BITS words (4096 by default) of the map to
// zero and takes no request meanwhile; frame_limit writes are taken at any time.
// An allocate scans one map word per cycle from word 0, over the whole words within
// frame_limit, and ends at the first word with a clear bit or reports full; the RAM
// read port sets that pace. A free divides the frame by WORD_BITS with a reciprocal,
// fixes the remainder, reads the map word and clears the bit; a no-op request goes
// straight to the response.
// One request is in work at a time; a finished result sits in the output register
// while the next request is taken.
`include "frame_bitmap_allocator_macros.svh"

module frame_bitmap_allocator #(
  parameter int MAX_FRAMES = 131072,
  parameter int WORD_BITS  = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  fba_req_if.sink    in_ch,
  fba_rsp_if.source  out_ch,
  fba_cfg_if.sink    cfg_ch
);

  localparam int FW        = fba_pkg::FRAME_W;
  localparam int CW        = fba_pkg::COUNT_W;
  localparam int MAP_WORDS = MAX_FRAMES / WORD_BITS;
  localparam int MEM_DEPTH = (MAP_WORDS > 0) ? MAP_WORDS : 1;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int BW        = $clog2(MAX_FRAMES + WORD_BITS + 1);
  localparam int CNT_W     = $clog2(MAX_FRAMES + 1);
  localparam int SH        = FW + BIT_W + 1;
  localparam int PW        = FW + SH;
  localparam logic [SH-1:0] RECIP = SH'((2 ** SH) / WORD_BITS);
  localparam logic [FW-1:0] WB_F  = FW'(WORD_BITS);
  localparam logic [BW-1:0] WB_B  = BW'(WORD_BITS);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_SCAN,
    S_FDIV,
    S_FREM,
    S_FCLR,
    S_RESP
  } state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         clr_a_r, clr_a_nxt;
  logic [CW-1:0]         tf_r, tf_nxt;
  logic [FW-1:0]         page_r, page_nxt;
  logic                  kern_r, kern_nxt;
  logic                  wr_r, wr_nxt;
  logic [AW-1:0]         scan_w_r, scan_w_nxt;
  logic [BW-1:0]         base_r, base_nxt;
  logic                  chk_valid_r, chk_valid_nxt;
  logic [AW-1:0]         chk_w_r, chk_w_nxt;
  logic [BW-1:0]         chk_base_r, chk_base_nxt;
  logic [FW-1:0]         q0_r, q0_nxt;
  logic [AW-1:0]         fw_r, fw_nxt;
  logic [BIT_W-1:0]      fbit_r, fbit_nxt;
  logic [CNT_W-1:0]      used_total_r, used_total_nxt;
  logic [FW-1:0]         res_frame_r, res_frame_nxt;
  logic                  res_pres_r, res_pres_nxt;
  logic                  res_wr_r, res_wr_nxt;
  logic                  res_user_r, res_user_nxt;
  fba_pkg::status_t      res_status_r, res_status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [FW-1:0]         out_frame_r, out_frame_nxt;
  logic                  out_pres_r, out_pres_nxt;
  logic                  out_wr_r, out_wr_nxt;
  logic                  out_user_r, out_user_nxt;
  fba_pkg::status_t      out_status_r, out_status_nxt;
  logic [CW-1:0]         out_count_r, out_count_nxt;

  logic [WORD_BITS-1:0]  map_mem [MEM_DEPTH];
  logic [WORD_BITS-1:0]  rd_data_r;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0]  mem_wdata;

  logic                  lf_found;
  logic [BIT_W-1:0]      lf_idx;
  logic [WORD_BITS-1:0]  lf_onehot;

  logic [BW-1:0]         tf_lim;
  logic                  issue_ok;
  logic                  in_acc;
  logic                  alloc_hit;
  logic [CNT_W-1:0]      used_inc;
  logic                  wr_state;
  logic [PW-1:0]         prod;
  logic [FW-1:0]         rem0;
  logic [FW-1:0]         q_fix;
  logic [FW-1:0]         r_fix;
  logic [WORD_BITS-1:0]  fmask;

  fba_lowfree #(.WORD_BITS(WORD_BITS)) u_lowfree (
    .word   (rd_data_r),
    .found  (lf_found),
    .idx    (lf_idx),
    .onehot (lf_onehot)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_number = out_frame_r;
  assign out_ch.present      = out_pres_r;
  assign out_ch.writable     = out_wr_r;
  assign out_ch.user_mode    = out_user_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.used_count   = out_count_r;

  assign in_acc    = in_ch.valid && (state_r == S_IDLE);
  assign alloc_hit = (state_r == S_SCAN) && chk_valid_r && lf_found;
  assign used_inc  = used_total_r + CNT_W'(1);
  assign wr_state  = (state_r == S_CLR) || (state_r == S_SCAN) || (state_r == S_FCLR);

  always_comb begin
    // clamp to the map size; frames past the last whole word never get scanned
    if ({{(32-CW){1'b0}}, tf_r} > 32'(MAX_FRAMES)) begin
      tf_lim = BW'(MAX_FRAMES);
    end else begin
      tf_lim = BW'(tf_r);
    end
    issue_ok = (state_r == S_SCAN) && ((base_r + WB_B) <= tf_lim);

    // frame / WORD_BITS by reciprocal; the estimate is low by at most one
    prod  = PW'(page_r) * PW'(RECIP);
    rem0  = page_r - FW'(q0_r * WB_F);
    if (rem0 >= WB_F) begin
      q_fix = q0_r + FW'(1);
      r_fix = rem0 - WB_F;
    end else begin
      q_fix = q0_r;
      r_fix = rem0;
    end
    fmask = {{(WORD_BITS-1){1'b0}}, 1'b1} << fbit_r;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_a_nxt      = clr_a_r;
    tf_nxt         = tf_r;
    page_nxt       = page_r;
    kern_nxt       = kern_r;
    wr_nxt         = wr_r;
    scan_w_nxt     = scan_w_r;
    base_nxt       = base_r;
    chk_valid_nxt  = chk_valid_r;
    chk_w_nxt      = chk_w_r;
    chk_base_nxt   = chk_base_r;
    q0_nxt         = q0_r;
    fw_nxt         = fw_r;
    fbit_nxt       = fbit_r;
    used_total_nxt = used_total_r;
    res_frame_nxt  = res_frame_r;
    res_pres_nxt   = res_pres_r;
    res_wr_nxt     = res_wr_r;
    res_user_nxt   = res_user_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_frame_nxt  = out_frame_r;
    out_pres_nxt   = out_pres_r;
    out_wr_nxt     = out_wr_r;
    out_user_nxt   = out_user_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_waddr      = clr_a_r;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = scan_w_r;

    if (cfg_ch.valid) begin
      tf_nxt = cfg_ch.frame_limit;
    end

    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        if (clr_a_r == AW'(MEM_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_a_nxt = clr_a_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          page_nxt      = in_ch.page_frame;
          kern_nxt      = in_ch.kernel_mode;
          wr_nxt        = in_ch.want_write;
          res_frame_nxt = in_ch.page_frame;
          res_pres_nxt  = 1'b0;
          res_wr_nxt    = 1'b0;
          res_user_nxt  = 1'b0;
          scan_w_nxt    = '0;
          base_nxt      = '0;
          chk_valid_nxt = 1'b0;
          if (in_ch.page_frame == '0) begin
            if (in_ch.func == fba_pkg::FUNC_ALLOC) begin
              state_nxt = S_SCAN;
            end else begin
              res_status_nxt = fba_pkg::ST_NOOP;
              state_nxt      = S_RESP;
            end
          end else begin
            if (in_ch.func == fba_pkg::FUNC_FREE) begin
              state_nxt = S_FDIV;
            end else begin
              res_status_nxt = fba_pkg::ST_NOOP;
              state_nxt      = S_RESP;
            end
          end
        end
      end

      S_SCAN: begin
        // read of word w overlaps the check of word w-1
        mem_re    = issue_ok;
        mem_raddr = scan_w_r;
        if (alloc_hit) begin
          mem_we         = 1'b1;
          mem_waddr      = chk_w_r;
          mem_wdata      = rd_data_r | lf_onehot;
          used_total_nxt = used_inc;
          res_frame_nxt  = FW'(chk_base_r + BW'(lf_idx));
          res_pres_nxt   = 1'b1;
          res_wr_nxt     = wr_r;
          res_user_nxt   = !kern_r;
          res_status_nxt = fba_pkg::ST_DONE;
          state_nxt      = S_RESP;
        end else if (!chk_valid_r && !issue_ok) begin
          res_status_nxt = fba_pkg::ST_FULL;
          state_nxt      = S_RESP;
        end else begin
          chk_valid_nxt = issue_ok;
          chk_w_nxt     = scan_w_r;
          chk_base_nxt  = base_r;
          if (issue_ok) begin
            scan_w_nxt = scan_w_r + AW'(1);
            base_nxt   = base_r + WB_B;
          end
        end
      end

      S_FDIV: begin
        q0_nxt    = FW'(prod >> SH);
        state_nxt = S_FREM;
      end

      S_FREM: begin
        res_frame_nxt  = '0;
        res_status_nxt = fba_pkg::ST_DONE;
        if (32'(q_fix) < 32'(MAP_WORDS)) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(q_fix);
          fw_nxt    = AW'(q_fix);
          fbit_nxt  = BIT_W'(r_fix);
          state_nxt = S_FCLR;
        end else begin
          state_nxt = S_RESP;
        end
      end

      S_FCLR: begin
        mem_we    = 1'b1;
        mem_waddr = fw_r;
        mem_wdata = rd_data_r & ~fmask;
        if (((rd_data_r & fmask) != '0) && (used_total_r != '0)) begin
          used_total_nxt = used_total_r - CNT_W'(1);
        end
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_frame_nxt  = res_frame_r;
          out_pres_nxt   = res_pres_r;
          out_wr_nxt     = res_wr_r;
          out_user_nxt   = res_user_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = CW'(used_total_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_a_r      <= '0;
      tf_r         <= fba_pkg::TF_RESET;
      chk_valid_r  <= 1'b0;
      used_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_a_r      <= clr_a_nxt;
      tf_r         <= tf_nxt;
      chk_valid_r  <= chk_valid_nxt;
      used_total_r <= used_total_nxt;
      out_valid_r  <= out_valid_nxt;
      page_r       <= page_nxt;
      kern_r       <= kern_nxt;
      wr_r         <= wr_nxt;
      scan_w_r     <= scan_w_nxt;
      base_r       <= base_nxt;
      chk_w_r      <= chk_w_nxt;
      chk_base_r   <= chk_base_nxt;
      q0_r         <= q0_nxt;
      fw_r         <= fw_nxt;
      fbit_r       <= fbit_nxt;
      res_frame_r  <= res_frame_nxt;
      res_pres_r   <= res_pres_nxt;
      res_wr_r     <= res_wr_nxt;
      res_user_r   <= res_user_nxt;
      res_status_r <= res_status_nxt;
      out_frame_r  <= out_frame_nxt;
      out_pres_r   <= out_pres_nxt;
      out_wr_r     <= out_wr_nxt;
      out_user_r   <= out_user_nxt;
      out_status_r <= out_status_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= map_mem[mem_raddr];
    end
  end

  `FBA_ASSERT_NXT(a_one_request_at_a_time, in_acc, !in_ch.ready, "request taken while busy")
  `FBA_ASSERT_NOW(a_alloc_bit_was_free, alloc_hit, !rd_data_r[lf_idx], "allocated a used frame")
  `FBA_ASSERT_NXT(a_alloc_count, alloc_hit, used_total_r == $past(used_inc), "count not bumped")
  `FBA_ASSERT_NOW(a_map_write_states, mem_we, wr_state, "stray map write")

endmodule

[sv/fba_lowfree.sv]
// Lowest clear bit of a map word: isolate it with x & -x, then encode the one-hot.
module fba_lowfree #(
  parameter int WORD_BITS = 32,
  localparam int BIT_W = $clog2(WORD_BITS)
) (
  input  logic [WORD_BITS-1:0] word,
  output logic                 found,
  output logic [BIT_W-1:0]     idx,
  output logic [WORD_BITS-1:0] onehot
);

  logic [WORD_BITS-1:0] free_bits;

  always_comb begin
    free_bits = ~word;
    onehot    = free_bits & (~free_bits + WORD_BITS'(1));
    found     = |free_bits;
    idx       = '0;
    for (int p = 0; p < WORD_BITS; p++) begin
      if (onehot[p]) begin
        idx = idx | BIT_W'(p);
      end
    end
  end

endmodule
